>>> rtl/mbr_pkg.sv
// Package for the rotated-row bitmap reader: sizes, codes, state type and
// the request structs passed between the sequencer and the frame store.
// No dependencies.
package mbr_pkg;

  localparam int FB_BYTES      = 131072;
  localparam int FB_AW         = $clog2(FB_BYTES);
  localparam int ROW_BYTES_MAX = 128;
  localparam int WORD_W        = 32;
  localparam int WORDS_MAX     = ROW_BYTES_MAX / 4;
  localparam int HEIGHT_MAX    = WORDS_MAX * WORD_W;

  localparam int CFG_W   = 11;
  localparam int ROW_W   = 10;
  localparam int PIX_W   = 8;
  localparam int PITCH_W = CFG_W - 3;
  localparam int HM1_W   = 10;
  // (HEIGHT_MAX-1)*pitch + byte column needs one bit above the product
  localparam int SRC_AW  = HM1_W + PITCH_W + 1;
  localparam int BIT_W   = $clog2(WORD_W);

  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd800;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ROW  = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_DRAIN,
    S_PUSH,
    S_BAD
  } mbr_state_t;

  typedef struct packed {
    logic             en;
    logic [FB_AW-1:0] addr;
    logic [PIX_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic             zero;   // pad pixel or address past the store
    logic [FB_AW-1:0] addr;
  } rd_req_t;

endpackage

>>> rtl/mbr_frame_store.sv
// Framebuffer memory with one write and one registered read port, plus the
// bit picker and 32-bit shift register that packs one pixel per cycle while
// the read data is valid. Depends on mbr_pkg.
module mbr_frame_store
  import mbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  wr_req_t           wr,
  input  rd_req_t           rd,
  input  logic [2:0]        bit_sel,
  output logic [WORD_W-1:0] acc
);

  logic [PIX_W-1:0] mem [FB_BYTES];
  logic [PIX_W-1:0] rd_data;
  logic             rd_valid;
  logic             rd_zero;
  logic             pix;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd.en;
    end
  end

  always_ff @(posedge clk) begin
    rd_zero <= rd.zero;
  end

  // MSB-first: pixel x&7 sits at bit 7-(x&7)
  assign pix = rd_zero ? 1'b0 : rd_data[~bit_sel];

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      acc <= {acc[WORD_W-2:0], pix};
    end
  end

endmodule

>>> rtl/mono_bitmap_rotate_rows.sv
// Rotated-row reader for a 1 bpp MSB-first framebuffer (top level).
// A load word is written while idle. A row request runs a setup state, then
// per output word 32 pixel reads from the single framebuffer read port, a
// drain state and a hand-off state that waits while the output register is
// full; no new input word is taken until the row is done. A bad row gives
// one flagged word. Synchronous reset clears control and the registers to
// width 800 / height 480; the framebuffer itself is not cleared.
module mono_bitmap_rotate_rows
  import mbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB-style config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [FB_AW-1:0]  address,
  input  logic [PIX_W-1:0]  data,
  input  logic [ROW_W-1:0]  row,
  // output words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] word,
  output logic              last,
  output logic              bad_row
);

  // ---------------------------------------------------------------------
  // Configuration registers: width at 0x0, height at 0x4
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] src_width;
  logic [CFG_W-1:0] src_height;
  logic             cfg_wr;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= WIDTH_RST;
      src_height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:  src_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: src_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, src_width};
      REG_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, src_height};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Derived geometry. The user must change config only while idle (the block
  // does not enforce it), so these hold steady for the whole row.
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0]   h_sat;     // height clipped to HEIGHT_MAX
  logic [PITCH_W-1:0] pitch;     // bytes per source line
  logic [CFG_W-1:0]   sx;        // source column for this output row
  logic [HM1_W-1:0]   h_m1;

  assign h_sat = (src_height > CFG_W'(HEIGHT_MAX)) ? CFG_W'(HEIGHT_MAX) : src_height;
  assign pitch = src_width[CFG_W-1:3];
  assign h_m1  = HM1_W'(h_sat - CFG_W'(1));

  // ---------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------
  mbr_state_t         state;
  mbr_state_t         state_next;
  logic [ROW_W-1:0]   row_q;
  logic [SRC_AW-1:0]  src_addr;    // byte address of the pixel now issued
  logic [2:0]         bit_sel;
  logic [CFG_W-1:0]   col;         // output column now issued
  logic               last_word;
  logic               in_acc;
  logic               out_free;
  logic               is_load;
  logic               row_bad;
  logic               pad;
  logic               word_end;
  logic               push;        // load the output register this cycle
  logic               issue;
  wr_req_t            wr;
  rd_req_t            rd;
  logic [WORD_W-1:0]  acc;

  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;
  assign is_load  = (action == ACT_LOAD);
  assign row_bad  = ({1'b0, row} >= src_width);
  assign sx       = src_width - CFG_W'(1) - {1'b0, row_q};
  assign pad      = (col >= h_sat);
  assign word_end = (col[BIT_W-1:0] == BIT_W'(WORD_W - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && !is_load) begin
          if (row_bad) begin
            state_next = S_BAD;
          end else if (h_sat != '0) begin
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: state_next = S_READ;
      S_READ: begin
        if (word_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_PUSH;
      S_PUSH: begin
        if (out_free) begin
          state_next = last_word ? S_IDLE : S_READ;
        end
      end
      S_BAD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    push     = 1'b0;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_READ:  issue    = 1'b1;
      S_PUSH:  push     = out_free;
      S_BAD:   push     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row setup and per-pixel stepping: walk up the source column, one line
  // (pitch bytes) per output pixel
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_q <= row;
    end
    if (state == S_SETUP) begin
      src_addr <= SRC_AW'(h_m1 * pitch) + SRC_AW'(sx[CFG_W-1:3]);
      bit_sel  <= sx[2:0];
      col      <= '0;
    end else if (issue) begin
      src_addr <= src_addr - SRC_AW'(pitch);
      col      <= col + CFG_W'(1);
      if (word_end) begin
        last_word <= ((col + CFG_W'(1)) >= h_sat);
      end
    end
  end

  // memory requests
  always_comb begin
    wr.en   = in_acc && is_load && ({15'd0, address} < 32'(FB_BYTES));
    wr.addr = address;
    wr.data = data;
    rd.en   = issue;
    rd.zero = pad || (src_addr >= SRC_AW'(FB_BYTES));
    rd.addr = src_addr[FB_AW-1:0];
  end

  mbr_frame_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd      (rd),
    .bit_sel (bit_sel),
    .acc     (acc)
  );

  // ---------------------------------------------------------------------
  // Output register: frees the packer while the consumer is stalled
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (state == S_BAD) begin
        word    <= '0;
        last    <= 1'b1;
        bad_row <= 1'b1;
      end else begin
        word    <= acc;
        last    <= last_word;
        bad_row <= 1'b0;
      end
    end
  end

endmodule

>>> dv/mbr_row_checker.sv
// Checker for mono_bitmap_rotate_rows: watches the config port and both word
// channels, keeps its own copy of geometry and frame bytes, predicts words.
// Depends on mbr_pkg.
module mbr_row_checker
  import mbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              action,
  input  logic [FB_AW-1:0]  address,
  input  logic [PIX_W-1:0]  data,
  input  logic [ROW_W-1:0]  row,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [WORD_W-1:0] word,
  input  logic              last,
  input  logic              bad_row,
  output int                err_count,
  output int                words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              bad;
  } rot_word_t;

  logic [PIX_W-1:0] fb_shadow [FB_BYTES];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  rot_word_t        rot_words_due [$];

  // count a failure, true while still inside the print budget
  function automatic bit note_failure();
    err_count++;
    return err_count <= 10;
  endfunction

  // expected words of one rotated row at the current geometry
  task automatic predict_rotated_row(input logic [ROW_W-1:0] r);
    int unsigned h, pitch, sx, nwords, sy, addr, c, w;
    logic [PIX_W-1:0] src;
    rot_word_t rw;
    if (r >= width_reg) begin
      rw.word = '0;
      rw.last = 1'b1;
      rw.bad  = 1'b1;
      rot_words_due.push_back(rw);
      return;
    end
    h = (height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg;
    pitch = width_reg >> 3;
    sx = width_reg - 1 - r;
    nwords = (h + WORD_W - 1) / WORD_W;
    for (w = 0; w < nwords; w++) begin
      rw.word = '0;
      for (c = w * WORD_W; c < h && c < (w + 1) * WORD_W; c++) begin
        sy = h - 1 - c;
        addr = sy * pitch + (sx >> 3);
        src = (addr < FB_BYTES) ? fb_shadow[addr] : '0;
        rw.word[WORD_W - 1 - (c % WORD_W)] = src[PIX_W - 1 - (sx % PIX_W)];
      end
      rw.last = (w + 1 == nwords);
      rw.bad  = 1'b0;
      rot_words_due.push_back(rw);
    end
  endtask

  initial begin
    err_count = 0;
    words_due = 0;
  end

  always @(posedge clk) begin : watch
    rot_word_t due;
    logic [CFG_W-1:0] reg_val;
    if (rst) begin
      rot_words_due.delete();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
    end else begin
      // config port
      if (psel && penable && pready) begin
        reg_val = (paddr[2] == REG_WIDTH) ? width_reg : height_reg;
        if (pwrite) begin
          if (paddr[2] == REG_WIDTH) width_reg = pwdata[CFG_W-1:0];
          else height_reg = pwdata[CFG_W-1:0];
        end else if (prdata !== {{(32-CFG_W){1'b0}}, reg_val}) begin
          if (note_failure())
            $display("reg readback at %0h: exp %h got %h", paddr, reg_val, prdata);
        end
      end
      // results first: a word leaving now never belongs to a request taken now
      if (out_valid && out_ready) begin
        if (rot_words_due.size() == 0) begin
          if (note_failure())
            $display("unexpected word %h last %b bad_row %b", word, last, bad_row);
        end else begin
          due = rot_words_due.pop_front();
          if (word !== due.word || last !== due.last || bad_row !== due.bad) begin
            if (note_failure())
              $display("word mismatch: word exp %h got %h, last exp %b got %b, bad_row exp %b got %b",
                       due.word, word, due.last, last, due.bad, bad_row);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (action == ACT_LOAD) fb_shadow[address] = data;
        else predict_rotated_row(row);
      end
    end
    words_due = rot_words_due.size();
  end

endmodule

>>> dv/tb_mono_bitmap_rotate_rows.sv
// Top of the mono_bitmap_rotate_rows testbench: clock, reset, config writes,
// load/row word stimulus with random idling, and the verdict.
// Depends on mbr_pkg, mono_bitmap_rotate_rows and mbr_row_checker.
module tb_mono_bitmap_rotate_rows;
  import mbr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid, in_ready;
  logic              action;
  logic [FB_AW-1:0]  address;
  logic [PIX_W-1:0]  data;
  logic [ROW_W-1:0]  row;
  logic              out_valid, out_ready;
  logic [WORD_W-1:0] word;
  logic              last, bad_row;
  int                err_count, words_due;

  // stimulus-side view: current geometry and which frame bytes hold data
  int unsigned cur_w, cur_h;
  bit          written [FB_BYTES];
  int          items_sent;
  bit          tx_idle, rx_idle;

  mono_bitmap_rotate_rows dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .address(address), .data(data), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .word(word), .last(last), .bad_row(bad_row)
  );

  mbr_row_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .address(address), .data(data), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .word(word), .last(last), .bad_row(bad_row),
    .err_count(err_count), .words_due(words_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop; the real run is far shorter than this
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // receiver: random stall bursts while rx_idle is set, rare enough that long
  // stretches run without any
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_idle && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // All driving tasks start and end right after a falling edge.

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Present one input word, maybe after a gap, and hold it until taken.
  // Valid is left high so back-to-back words keep the channel busy.
  task automatic send_word(input logic act, input logic [FB_AW-1:0] a,
                           input logic [PIX_W-1:0] d, input logic [ROW_W-1:0] r);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    address  <= a;
    data     <= d;
    row      <= r;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(input int unsigned a, input logic [PIX_W-1:0] d);
    send_word(ACT_LOAD, a[FB_AW-1:0], d, ROW_W'($urandom));
    written[a] = 1'b1;
  endtask

  function automatic int unsigned eff_height();
    return (cur_h > HEIGHT_MAX) ? HEIGHT_MAX : cur_h;
  endfunction

  // Row request. Every frame byte the row will read is loaded first, so no
  // never-written byte is ever read; bytes past the store read as zero.
  task automatic ask_row(input int unsigned r);
    int unsigned pitch, col, a, sy;
    if (r < cur_w) begin
      pitch = cur_w >> 3;
      col = (cur_w - 1 - r) >> 3;
      for (sy = 0; sy < eff_height(); sy++) begin
        a = sy * pitch + col;
        if (a < FB_BYTES && !written[a]) send_load(a, $urandom_range(0, 255));
      end
    end
    send_word(ACT_ROW, FB_AW'($urandom), PIX_W'($urandom), r[ROW_W-1:0]);
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic drain_words();
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
  endtask

  // Geometry change with the block idle, after an extra wait. A zero-height
  // row gives no word and does not take the block out of idle.
  task automatic set_geometry(input int unsigned w, input int unsigned h);
    drain_words();
    repeat (80) @(negedge clk);
    apb_access(1'b1, REG_WIDTH, w);
    apb_access(1'b1, REG_HEIGHT, h);
    apb_access(1'b0, REG_WIDTH, '0);
    apb_access(1'b0, REG_HEIGHT, '0);
    cur_w = w;
    cur_h = h;
  endtask

  // Random traffic: mostly loads into the image plus a valid row request,
  // some out-of-range rows, some stray loads anywhere in the store.
  task automatic run_mix(input int n);
    int sent0, kind;
    int unsigned span, top_row;
    sent0 = items_sent;
    span = (cur_w >> 3) * eff_height();
    if (span > FB_BYTES) span = FB_BYTES;
    top_row = (cur_w > 1024) ? 1023 : cur_w - 1;
    while (items_sent - sent0 < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        repeat ($urandom_range(0, 3))
          send_load($urandom_range(0, span - 1), $urandom_range(0, 255));
        ask_row($urandom_range(0, top_row));
      end else if (kind < 80 && cur_w <= 1023) begin
        ask_row($urandom_range(cur_w, 1023));
      end else begin
        send_load($urandom_range(0, FB_BYTES - 1), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    int k;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    action     = ACT_LOAD;
    address    = '0;
    data       = '0;
    row        = '0;
    items_sent = 0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    cur_w      = WIDTH_RST;
    cur_h      = HEIGHT_RST;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset geometry 800x480: readback, then out-of-range rows only
    apb_access(1'b0, REG_WIDTH, '0);
    apb_access(1'b0, REG_HEIGHT, '0);
    ask_row(900);
    ask_row(1023);

    // small image, two words per row; store extremes, first/last/bad rows
    set_geometry(16, 40);
    send_load(0, 8'hFF);
    send_load(1, 8'h00);
    send_load(FB_BYTES - 1, 8'hFF);
    send_load(FB_BYTES - 2, 8'h00);
    ask_row(0);
    ask_row(15);
    ask_row(16);
    ask_row(1023);

    // zero height: valid row gives nothing, bad row still flagged
    set_geometry(16, 0);
    ask_row(3);
    ask_row(20);

    // single-pixel rows
    set_geometry(16, 1);
    ask_row(3);
    ask_row(12);

    // width 1024 (every row reachable by the 10-bit row index), highest row index
    set_geometry(1024, 3);
    ask_row(1023);
    ask_row(0);

    // assorted geometries, mostly small, with random traffic
    set_geometry(24, 33);
    run_mix(45);
    set_geometry(64, 16);
    rx_idle = 1'b0;
    run_mix(45);
    rx_idle = 1'b1;
    set_geometry(13, 47);
    run_mix(45);
    set_geometry(1024, 5);
    run_mix(40);
    set_geometry(40, 1);
    run_mix(40);
    tx_idle = 1'b0;
    run_mix(20);
    tx_idle = 1'b1;
    // sender holds off until the block has delivered everything
    drain_words();
    @(negedge clk);
    run_mix(20);
    set_geometry(8 + 8 * $urandom_range(0, 11), $urandom_range(2, 70));
    run_mix(45);

    // final stretch with no idling on either side
    set_geometry(32, 64);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_mix(60);

    in_valid <= 1'b0;
    for (k = 0; k < 20000 && words_due != 0; k++) @(negedge clk);
    repeat (100) @(negedge clk);
    if (err_count == 0 && words_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mbr_pkg.sv
rtl/mbr_frame_store.sv
rtl/mono_bitmap_rotate_rows.sv
dv/mbr_row_checker.sv
dv/tb_mono_bitmap_rotate_rows.sv
